[hw/rtl/pdp_pkg.sv]
// Shared types, constants and float helpers for the point dedup pool.
package pdp_pkg;

    localparam int POOL_POINTS   = 1024;
    localparam int INDEX_ENTRIES = 1024;
    localparam int MAX_WIDTH     = 8;
    localparam int COMP_W        = 32;
    localparam int PA_W          = $clog2(POOL_POINTS);
    localparam int IA_W          = $clog2(INDEX_ENTRIES);
    localparam int CNT_W         = PA_W + 1;
    localparam int AW_W          = 4;
    localparam int BOUND_AXES    = 3;

    localparam logic [2:0] CMD_ACC    = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_GET    = 3'd3;
    localparam logic [2:0] CMD_BOUNDS = 3'd4;
    localparam logic [2:0] CMD_RESIZE = 3'd5;
    localparam logic [2:0] CMD_CLEAR  = 3'd6;

    localparam logic [2:0] ST_NEW        = 3'd0;
    localparam logic [2:0] ST_FOUND      = 3'd1;
    localparam logic [2:0] ST_POOL_FULL  = 3'd2;
    localparam logic [2:0] ST_INDEX_FULL = 3'd3;
    localparam logic [2:0] ST_RANGE      = 3'd4;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_MIN   = 2'd2;
    localparam logic [1:0] KIND_MAX   = 2'd3;

    typedef logic [MAX_WIDTH-1:0][COMP_W-1:0] pt_vec_t;

    typedef struct packed {
        pt_vec_t         pt;
        logic [PA_W-1:0] tgt;
    } key_row_t;

    typedef struct packed {
        logic       load;
        logic       kscan_go;
        logic       bscan_go;
        logic       scan_step;
        logic       app_wr;
        logic       set_wr;
        logic       key_wr;
        logic       get_rd;
        logic       fill_go;
        logic       fill_wr;
        logic       rsz_commit;
        logic       clr;
        logic       st_we;
        logic [2:0] st_val;
        logic       rs_hit;
        logic       res_ld;
        logic [1:0] res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       slot_bad;
        logic       rsz_bad;
        logic       pool_full;
        logic       idx_full;
        logic       bnd_none;
        logic       scan_done;
        logic       scan_hit;
        logic       fill_done;
        logic       out_busy;
    } dp_stat_t;

    function automatic logic comp_eq(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
        return (a == b) || ((a[COMP_W-2:0] == '0) && (b[COMP_W-2:0] == '0));
    endfunction

    function automatic logic f_lt(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
        logic r;
        if ((a[COMP_W-2:0] == '0) && (b[COMP_W-2:0] == '0))
        begin
            r = 1'b0;
        end
        else if (a[COMP_W-1] != b[COMP_W-1])
        begin
            r = a[COMP_W-1];
        end
        else if (!a[COMP_W-1])
        begin
            r = a[COMP_W-2:0] < b[COMP_W-2:0];
        end
        else
        begin
            r = a[COMP_W-2:0] > b[COMP_W-2:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/pdp_datapath.sv]
// Pool and key memories, scan pointer, comparators, bounds folding and output register.
module pdp_datapath
    import pdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd_i,
    output dp_stat_t             stat_o,
    input  logic                 cfg_we,
    input  logic [AW_W-1:0]      cfg_wdata,
    input  logic [2:0]           in_cmd,
    input  logic [CNT_W-1:0]     in_slot,
    input  pt_vec_t              in_pt,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [PA_W-1:0]      out_slot,
    output logic [CNT_W-1:0]     out_total,
    output logic [2:0]           out_status,
    output pt_vec_t              out_pt,
    output logic                 out_last
);

    pt_vec_t            point_mem [POOL_POINTS];
    key_row_t           key_mem [INDEX_ENTRIES];

    logic [AW_W-1:0]    point_width_reg;
    logic [CNT_W-1:0]   point_count_reg;
    logic [CNT_W-1:0]   key_count_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic               pend_reg;
    logic               first_reg;
    logic               bmode_reg;
    logic               out_valid_reg;

    logic [2:0]         cmd_reg;
    logic [CNT_W-1:0]   slot_reg;
    pt_vec_t            pt_reg;
    logic [PA_W-1:0]    res_slot_reg;
    logic [2:0]         res_status_reg;
    pt_vec_t            rd_pt_reg;
    key_row_t           rd_key_reg;
    logic [BOUND_AXES-1:0][COMP_W-1:0] min_reg;
    logic [BOUND_AXES-1:0][COMP_W-1:0] max_reg;
    logic [PA_W-1:0]    out_slot_reg;
    logic [CNT_W-1:0]   out_total_reg;
    logic [2:0]         out_status_reg;
    pt_vec_t            out_pt_reg;
    logic               out_last_reg;

    logic [AW_W-1:0]    aw;
    pt_vec_t            in_masked;
    pt_vec_t            rd_masked;
    logic               key_match;
    logic [CNT_W-1:0]   limit;
    logic               scan_hit;
    logic               issue;
    logic               pt_we;
    logic [PA_W-1:0]    pt_wa;
    pt_vec_t            pt_wd;
    logic               pt_re;
    logic [PA_W-1:0]    pt_ra;
    logic               key_re;
    key_row_t           key_wd;

    always_comb
    begin
        if (point_width_reg == '0)
        begin
            aw = AW_W'(1);
        end
        else if (point_width_reg > AW_W'(MAX_WIDTH))
        begin
            aw = AW_W'(MAX_WIDTH);
        end
        else
        begin
            aw = point_width_reg;
        end
    end

    always_comb
    begin
        key_match = 1'b1;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            in_masked[i] = (AW_W'(i) < aw) ? in_pt[i] : '0;
            rd_masked[i] = (AW_W'(i) < aw) ? rd_pt_reg[i] : '0;
            if ((AW_W'(i) < aw) && !comp_eq(rd_key_reg.pt[i], pt_reg[i]))
            begin
                key_match = 1'b0;
            end
        end
    end

    assign limit    = bmode_reg ? point_count_reg : key_count_reg;
    assign scan_hit = !bmode_reg && pend_reg && key_match;
    assign issue    = cmd_i.scan_step && (ptr_reg < limit) && !scan_hit;

    always_comb
    begin
        pt_we = cmd_i.app_wr || cmd_i.set_wr || cmd_i.fill_wr;
        pt_wd = pt_reg;
        pt_wa = ptr_reg[PA_W-1:0];
        priority if (cmd_i.app_wr)
        begin
            pt_wa = point_count_reg[PA_W-1:0];
        end
        else if (cmd_i.set_wr)
        begin
            pt_wa = slot_reg[PA_W-1:0];
        end
        else
        begin
            pt_wd = '0;
        end
        pt_re  = cmd_i.get_rd || (issue && bmode_reg);
        pt_ra  = cmd_i.get_rd ? slot_reg[PA_W-1:0] : ptr_reg[PA_W-1:0];
        key_re = issue && !bmode_reg;
        key_wd.pt  = pt_reg;
        key_wd.tgt = (cmd_reg == CMD_SET) ? slot_reg[PA_W-1:0] : res_slot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            point_mem[pt_wa] <= pt_wd;
        end
        if (pt_re)
        begin
            rd_pt_reg <= point_mem[pt_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.key_wr)
        begin
            key_mem[key_count_reg[IA_W-1:0]] <= key_wd;
        end
        if (key_re)
        begin
            rd_key_reg <= key_mem[ptr_reg[IA_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_width_reg <= AW_W'(MAX_WIDTH);
            point_count_reg <= '0;
            key_count_reg   <= '0;
            ptr_reg         <= '0;
            pend_reg        <= 1'b0;
            first_reg       <= 1'b0;
            bmode_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                point_width_reg <= cfg_wdata;
            end

            if (cmd_i.clr)
            begin
                point_count_reg <= '0;
                key_count_reg   <= '0;
            end
            else if (cmd_i.rsz_commit)
            begin
                point_count_reg <= slot_reg;
                key_count_reg   <= '0;
            end
            else
            begin
                if (cmd_i.app_wr)
                begin
                    point_count_reg <= point_count_reg + CNT_W'(1);
                end
                if (cmd_i.key_wr)
                begin
                    key_count_reg <= key_count_reg + CNT_W'(1);
                end
            end

            if (cmd_i.kscan_go || cmd_i.bscan_go)
            begin
                ptr_reg   <= '0;
                pend_reg  <= 1'b0;
                first_reg <= 1'b1;
                bmode_reg <= cmd_i.bscan_go;
            end
            else if (cmd_i.fill_go)
            begin
                ptr_reg <= point_count_reg;
            end
            else if (cmd_i.fill_wr)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            else if (cmd_i.scan_step)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
                if (bmode_reg && pend_reg)
                begin
                    first_reg <= 1'b0;
                end
            end

            if (cmd_i.res_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            cmd_reg        <= in_cmd;
            slot_reg       <= in_slot;
            pt_reg         <= in_masked;
            res_slot_reg   <= '0;
            res_status_reg <= ST_NEW;
        end
        else
        begin
            if (cmd_i.st_we)
            begin
                res_status_reg <= cmd_i.st_val;
            end
            if (cmd_i.app_wr)
            begin
                res_slot_reg <= point_count_reg[PA_W-1:0];
            end
            else if (cmd_i.rs_hit)
            begin
                res_slot_reg <= rd_key_reg.tgt;
            end
        end

        if (cmd_i.scan_step && bmode_reg && pend_reg)
        begin
            for (int a = 0; a < BOUND_AXES; a++)
            begin
                if (first_reg || f_lt(rd_pt_reg[a], min_reg[a]))
                begin
                    min_reg[a] <= rd_pt_reg[a];
                end
                if (first_reg || f_lt(max_reg[a], rd_pt_reg[a]))
                begin
                    max_reg[a] <= rd_pt_reg[a];
                end
            end
        end

        if (cmd_i.res_ld)
        begin
            out_slot_reg   <= res_slot_reg;
            out_total_reg  <= point_count_reg;
            out_status_reg <= res_status_reg;
            out_last_reg   <= (cmd_i.res_kind != KIND_MIN);
            unique case (cmd_i.res_kind)
                KIND_GET:
                begin
                    out_pt_reg <= rd_masked;
                end
                KIND_MIN:
                begin
                    out_pt_reg <= {{((MAX_WIDTH - BOUND_AXES) * COMP_W){1'b0}}, min_reg};
                end
                KIND_MAX:
                begin
                    out_pt_reg <= {{((MAX_WIDTH - BOUND_AXES) * COMP_W){1'b0}}, max_reg};
                end
                default:
                begin
                    out_pt_reg <= '0;
                end
            endcase
        end
    end

    always_comb
    begin
        stat_o.cmd       = cmd_reg;
        stat_o.slot_bad  = slot_reg >= point_count_reg;
        stat_o.rsz_bad   = slot_reg > CNT_W'(POOL_POINTS);
        stat_o.pool_full = point_count_reg >= CNT_W'(POOL_POINTS);
        stat_o.idx_full  = key_count_reg >= CNT_W'(INDEX_ENTRIES);
        stat_o.bnd_none  = (point_count_reg == '0) || (aw < AW_W'(BOUND_AXES));
        stat_o.scan_done = scan_hit || (!pend_reg && (ptr_reg >= limit));
        stat_o.scan_hit  = scan_hit;
        stat_o.fill_done = ptr_reg >= slot_reg;
        stat_o.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_slot   = out_slot_reg;
    assign out_total  = out_total_reg;
    assign out_status = out_status_reg;
    assign out_pt     = out_pt_reg;
    assign out_last   = out_last_reg;

endmodule

[hw/rtl/pdp_ctrl.sv]
// Command sequencer for the point dedup pool.
module pdp_ctrl
    import pdp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat_i,
    output dp_cmd_t  cmd_o
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_APPEND   = 4'd3;
    localparam logic [3:0] S_INDEX    = 4'd4;
    localparam logic [3:0] S_GETW     = 4'd5;
    localparam logic [3:0] S_BSCAN    = 4'd6;
    localparam logic [3:0] S_FILL     = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;
    localparam logic [3:0] S_EMIT_GET = 4'd9;
    localparam logic [3:0] S_EMIT_MIN = 4'd10;
    localparam logic [3:0] S_EMIT_MAX = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_o      = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_o.load = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat_i.cmd)
                    CMD_ACC:
                    begin
                        cmd_o.kscan_go = 1'b1;
                        state_next     = S_SCAN;
                    end
                    CMD_APPEND:
                    begin
                        state_next = S_APPEND;
                    end
                    CMD_SET:
                    begin
                        if (stat_i.slot_bad)
                        begin
                            cmd_o.st_we  = 1'b1;
                            cmd_o.st_val = ST_RANGE;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            cmd_o.set_wr   = 1'b1;
                            cmd_o.kscan_go = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    CMD_GET:
                    begin
                        if (stat_i.slot_bad)
                        begin
                            cmd_o.st_we  = 1'b1;
                            cmd_o.st_val = ST_RANGE;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            cmd_o.get_rd = 1'b1;
                            state_next   = S_GETW;
                        end
                    end
                    CMD_BOUNDS:
                    begin
                        if (stat_i.bnd_none)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd_o.bscan_go = 1'b1;
                            state_next     = S_BSCAN;
                        end
                    end
                    CMD_RESIZE:
                    begin
                        if (stat_i.rsz_bad)
                        begin
                            cmd_o.st_we  = 1'b1;
                            cmd_o.st_val = ST_RANGE;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            cmd_o.fill_go = 1'b1;
                            state_next    = S_FILL;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        cmd_o.clr  = 1'b1;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd_o.scan_step = 1'b1;
                if (stat_i.scan_done)
                begin
                    if (stat_i.scan_hit)
                    begin
                        cmd_o.st_we = 1'b1;
                        if (stat_i.cmd == CMD_ACC)
                        begin
                            cmd_o.rs_hit = 1'b1;
                            cmd_o.st_val = ST_FOUND;
                        end
                        else if (stat_i.cmd == CMD_SET)
                        begin
                            cmd_o.st_val = ST_FOUND;
                        end
                        else
                        begin
                            cmd_o.st_val = ST_NEW;
                        end
                        state_next = S_EMIT;
                    end
                    else if (stat_i.cmd == CMD_ACC)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_INDEX;
                    end
                end
            end
            S_APPEND:
            begin
                if (stat_i.pool_full)
                begin
                    cmd_o.st_we  = 1'b1;
                    cmd_o.st_val = ST_POOL_FULL;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd_o.app_wr = 1'b1;
                    if (stat_i.cmd == CMD_ACC)
                    begin
                        state_next = S_INDEX;
                    end
                    else
                    begin
                        cmd_o.kscan_go = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_INDEX:
            begin
                cmd_o.st_we = 1'b1;
                if (stat_i.idx_full)
                begin
                    cmd_o.st_val = ST_INDEX_FULL;
                end
                else
                begin
                    cmd_o.key_wr = 1'b1;
                    cmd_o.st_val = ST_NEW;
                end
                state_next = S_EMIT;
            end
            S_GETW:
            begin
                state_next = S_EMIT_GET;
            end
            S_BSCAN:
            begin
                cmd_o.scan_step = 1'b1;
                if (stat_i.scan_done)
                begin
                    state_next = S_EMIT_MIN;
                end
            end
            S_FILL:
            begin
                if (stat_i.fill_done)
                begin
                    cmd_o.rsz_commit = 1'b1;
                    state_next       = S_EMIT;
                end
                else
                begin
                    cmd_o.fill_wr = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!stat_i.out_busy)
                begin
                    cmd_o.res_ld   = 1'b1;
                    cmd_o.res_kind = KIND_PLAIN;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT_GET:
            begin
                if (!stat_i.out_busy)
                begin
                    cmd_o.res_ld   = 1'b1;
                    cmd_o.res_kind = KIND_GET;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT_MIN:
            begin
                if (!stat_i.out_busy)
                begin
                    cmd_o.res_ld   = 1'b1;
                    cmd_o.res_kind = KIND_MIN;
                    state_next     = S_EMIT_MAX;
                end
            end
            S_EMIT_MAX:
            begin
                if (!stat_i.out_busy)
                begin
                    cmd_o.res_ld   = 1'b1;
                    cmd_o.res_kind = KIND_MAX;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/point_dedup_pool_core.sv]
// Top level of the point dedup pool: sequencer, datapath and port mapping.
//
//   channel  handshake              word
//   in       in_valid / in_ready    cmd, slot, in_c0..in_c7
//   out      out_valid / out_ready  result_slot, point_total, status, out_c0..out_c7, last
//   cfg      cfg_valid / cfg_ready  cfg_data (point width)
//
// One command at a time. Accumulate, append and set walk the key memory linearly, so
// their time grows with the key count; bounds walks the pool memory and grows with the
// point count; resize zero-fills each slot past the old count in turn. Reset clears
// counts and sets the width to 8; no clearing pass.
// A stalled output holds the finished word while the sequencer waits to load the next.
module point_dedup_pool_core
    import pdp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          cmd,
    input  logic [CNT_W-1:0]    slot,
    input  logic [COMP_W-1:0]   in_c0,
    input  logic [COMP_W-1:0]   in_c1,
    input  logic [COMP_W-1:0]   in_c2,
    input  logic [COMP_W-1:0]   in_c3,
    input  logic [COMP_W-1:0]   in_c4,
    input  logic [COMP_W-1:0]   in_c5,
    input  logic [COMP_W-1:0]   in_c6,
    input  logic [COMP_W-1:0]   in_c7,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PA_W-1:0]     result_slot,
    output logic [CNT_W-1:0]    point_total,
    output logic [2:0]          status,
    output logic [COMP_W-1:0]   out_c0,
    output logic [COMP_W-1:0]   out_c1,
    output logic [COMP_W-1:0]   out_c2,
    output logic [COMP_W-1:0]   out_c3,
    output logic [COMP_W-1:0]   out_c4,
    output logic [COMP_W-1:0]   out_c5,
    output logic [COMP_W-1:0]   out_c6,
    output logic [COMP_W-1:0]   out_c7,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [AW_W-1:0]     cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    pt_vec_t  in_pt;
    pt_vec_t  out_pt;

    assign in_pt     = {in_c7, in_c6, in_c5, in_c4, in_c3, in_c2, in_c1, in_c0};
    assign cfg_ready = 1'b1;

    pdp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat_i   (dp_stat),
        .cmd_o    (dp_cmd)
    );

    pdp_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_i      (dp_cmd),
        .stat_o     (dp_stat),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_wdata  (cfg_data),
        .in_cmd     (cmd),
        .in_slot    (slot),
        .in_pt      (in_pt),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_slot   (result_slot),
        .out_total  (point_total),
        .out_status (status),
        .out_pt     (out_pt),
        .out_last   (last)
    );

    assign out_c0 = out_pt[0];
    assign out_c1 = out_pt[1];
    assign out_c2 = out_pt[2];
    assign out_c3 = out_pt[3];
    assign out_c4 = out_pt[4];
    assign out_c5 = out_pt[5];
    assign out_c6 = out_pt[6];
    assign out_c7 = out_pt[7];

`ifndef SYNTH
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in flight");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_total <= CNT_W'(POOL_POINTS))
        else $error("point total beyond pool size");

    a_min_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == ST_NEW && result_slot == '0)
        else $error("bounds min word carries slot or status");
`endif

endmodule
